[rtl/core/rwc_pkg.sv]
// Package for the raster wait coprocessor: widths, state codes, register
// indexes, shared types and the raster compare function.
// No dependencies.
package rwc_pkg;

  localparam int PTR_W  = 20;
  localparam int POS_W  = 16;
  localparam int WORD_W = 16;
  localparam int REG_W  = 9;
  localparam int CFG_W  = 20;
  localparam int IDX_W  = 2;

  localparam logic [1:0] ST_STOPPED = 2'd0;
  localparam logic [1:0] ST_WAITING = 2'd1;
  localparam logic [1:0] ST_FIRST   = 2'd2;
  localparam logic [1:0] ST_SECOND  = 2'd3;

  localparam logic [IDX_W-1:0] CFG_DANGER = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MASK   = 2'd1;
  localparam logic [IDX_W-1:0] CFG_START  = 2'd2;

  localparam logic [REG_W-1:0] PROT_LOW    = 9'h010;
  localparam logic [REG_W-1:0] PROT_DANGER = 9'h020;

  localparam logic             DANGER_RST = 1'b0;
  localparam logic [CFG_W-1:0] MASK_RST   = 20'hFFFFF;
  localparam logic [CFG_W-1:0] START_RST  = 20'h00000;

  typedef struct packed {
    logic [1:0]        mstate;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
    logic [PTR_W-1:0]  fetch_pointer;
    logic              skip_pending;
  } cop_state_t;

  typedef struct packed {
    logic              slot_used;
    logic [PTR_W-1:0]  fetch_address;
    logic              reg_write_valid;
    logic [REG_W-1:0]  reg_address;
    logic [WORD_W-1:0] reg_value;
    logic              halted;
  } cop_result_t;

  function automatic logic raster_reached(
    input logic [WORD_W-1:0] first_w,
    input logic [WORD_W-1:0] second_w,
    input logic [POS_W-1:0]  pos,
    input logic              busy
  );
    logic [POS_W-1:0] mask;
    mask = {1'b1, second_w[14:1], 1'b0};
    return !(!second_w[15] && busy) && ((pos & mask) >= (first_w & mask));
  endfunction

endpackage

[rtl/core/raster_wait_coprocessor.sv]
// Raster wait coprocessor top level: input word register, machine state,
// configuration registers and result register. Depends on rwc_pkg, rwc_step.
//
// Usage: each input word offers one memory slot and carries the beam
// position, the blitter busy flag and the memory word at the fetch address
// reported by the result word of that same slot. Every input word yields
// exactly one result word: slot use, fetch address, an optional register
// write (MOVE) and the halted flag.
// Order: an accepted input word is held in the input register, then the
// result word is registered in the result register; out_valid rises with
// the result word, which is taken at an edge where out_ready is high.
// Throughput: one word per cycle while out_ready is high; back-pressure
// on out_ready holds the result register and then stops new words.
// Stall: while out_ready is low the result register holds; the input
// register still takes one more word, then in_ready drops.
// Reset (rst_n low, synchronous): machine fetches the first word, fetch
// pointer loads the list_start reset value (0), address_mask is all ones, danger is off,
// both channels empty. Writing list_start loads the fetch pointer directly;
// write configuration only while the block is idle.
module raster_wait_coprocessor import rwc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [POS_W-1:0]  in_beam_position,
  input  logic              in_blitter_busy,
  input  logic [WORD_W-1:0] in_fetch_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_slot_used,
  output logic [PTR_W-1:0]  out_fetch_address,
  output logic              out_reg_write_valid,
  output logic [REG_W-1:0]  out_reg_address,
  output logic [WORD_W-1:0] out_reg_value,
  output logic              out_halted,
  input  logic              cfg_write_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic              in_v_r;
  logic [POS_W-1:0]  pos_r;
  logic              busy_r;
  logic [WORD_W-1:0] data_r;
  logic              out_v_r;
  cop_result_t       res_r;
  cop_state_t        st_r;
  cop_state_t        st_nxt;
  cop_result_t       res_nxt;
  logic              danger_r;
  logic [CFG_W-1:0]  mask_r;
  logic              advance;

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  rwc_step u_step (
    .cur           (st_r),
    .danger_enable (danger_r),
    .address_mask  (mask_r),
    .beam_position (pos_r),
    .blitter_busy  (busy_r),
    .fetch_data    (data_r),
    .nxt           (st_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      pos_r  <= in_beam_position;
      busy_r <= in_blitter_busy;
      data_r <= in_fetch_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      danger_r         <= DANGER_RST;
      mask_r           <= MASK_RST;
      st_r.mstate      <= ST_FIRST;
      st_r.first_word  <= '0;
      st_r.second_word <= '0;
      st_r.fetch_pointer <= START_RST;
      st_r.skip_pending  <= 1'b0;
    end else begin
      if (advance) begin
        st_r <= st_nxt;
      end
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_DANGER: danger_r <= cfg_data[0];
          CFG_MASK:   mask_r   <= cfg_data;
          CFG_START: begin
            st_r.fetch_pointer <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid           = out_v_r;
  assign out_slot_used       = res_r.slot_used;
  assign out_fetch_address   = res_r.fetch_address;
  assign out_reg_write_valid = res_r.reg_write_valid;
  assign out_reg_address     = res_r.reg_address;
  assign out_reg_value       = res_r.reg_value;
  assign out_halted          = res_r.halted;

`ifndef SYNTH
  a_stop_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.mstate == ST_STOPPED) |=> (st_r.mstate == ST_STOPPED))
    else $error("stopped machine left stopped state");
  a_write_uses_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reg_write_valid) |-> (out_slot_used && !out_halted))
    else $error("register write without a fetch");
  a_write_unprotected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reg_write_valid) |->
      (out_reg_address >= PROT_LOW && (danger_r || out_reg_address >= PROT_DANGER)))
    else $error("write to protected register");
  a_state_follows_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance && !cfg_write_en) |=> $stable(st_r))
    else $error("machine state changed without a slot");
`endif

endmodule

[rtl/core/rwc_step.sv]
// One slot of the coprocessor: next machine state and result word.
// Depends on rwc_pkg.
module rwc_step import rwc_pkg::*; (
  input  cop_state_t        cur,
  input  logic              danger_enable,
  input  logic [CFG_W-1:0]  address_mask,
  input  logic [POS_W-1:0]  beam_position,
  input  logic              blitter_busy,
  input  logic [WORD_W-1:0] fetch_data,
  output cop_state_t        nxt,
  output cop_result_t       res
);

  logic [REG_W-1:0] target;
  logic             protect;

  assign target  = {cur.first_word[8:1], 1'b0};
  assign protect = (target < PROT_LOW) || ((target < PROT_DANGER) && !danger_enable);

  always_comb begin
    nxt = cur;
    res = '0;
    case (cur.mstate)
      ST_WAITING: begin
        if (raster_reached(cur.first_word, cur.second_word, beam_position, blitter_busy)) begin
          nxt.mstate = ST_FIRST;
        end
      end
      ST_FIRST: begin
        res.slot_used     = 1'b1;
        res.fetch_address = cur.fetch_pointer & address_mask;
        nxt.first_word    = fetch_data;
        nxt.fetch_pointer = cur.fetch_pointer + 1'b1;
        nxt.mstate        = ST_SECOND;
      end
      ST_SECOND: begin
        res.slot_used     = 1'b1;
        res.fetch_address = cur.fetch_pointer & address_mask;
        nxt.second_word   = fetch_data;
        nxt.fetch_pointer = cur.fetch_pointer + 1'b1;
        nxt.skip_pending  = 1'b0;
        if (!cur.first_word[0]) begin
          nxt.mstate = ST_FIRST;
          if (!cur.skip_pending) begin
            if (protect) begin
              nxt.mstate = ST_STOPPED;
            end else begin
              res.reg_write_valid = 1'b1;
              res.reg_address     = target;
              res.reg_value       = fetch_data;
            end
          end
        end else if (!fetch_data[0]) begin
          nxt.mstate = ST_WAITING;
        end else begin
          nxt.skip_pending = raster_reached(cur.first_word, fetch_data, beam_position,
                                            blitter_busy);
          nxt.mstate       = ST_FIRST;
        end
      end
      default: begin
      end
    endcase
    res.halted = (nxt.mstate == ST_STOPPED);
  end

endmodule
